// ===== src/ssca_pkg.sv =====
// Shared types, constants and codes for the slab size-class allocator.
// No dependencies; every other file imports this package.
package ssca_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int STACK_DEPTH = 64;

  localparam int SIZE_W   = 20;
  localparam int ADDR_W   = 32;
  localparam int STAT_W   = 3;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ARG    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_CLASS   = 3'd2;
  localparam logic [STAT_W-1:0] ST_HEAP_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_STACK_FULL = 3'd4;

  // Register indexes (class sizes occupy 0 .. 3)
  localparam logic [REG_IDX_W-1:0] REG_CLASS_SIZE_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_BASE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_LIMIT   = 3'd5;

  localparam logic [3:0][SIZE_W-1:0] CLASS_RESET = {20'd128, 20'd64, 20'd32, 20'd16};
  localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'd4096;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [NUM_CLASSES-1:0][SIZE_W-1:0] class_size;
    logic [ADDR_W-1:0]                  heap_base;
    logic [ADDR_W-1:0]                  heap_limit;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CLS_W-1:0]  cls;
  } match_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] wdata;
  } stk_req_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

endpackage

// ===== src/ssca_cfg_regs.sv =====
// Configuration register file: class sizes, heap base and heap limit.
// Depends on ssca_pkg.
module ssca_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ssca_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ssca_pkg::CFG_DATA_W-1:0] cfg_data,
  output ssca_pkg::cfg_t                  cfg
);
  import ssca_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en = cfg_valid && cfg_ready;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cfg_r.class_size[i] <= CLASS_RESET[i];
      end
      cfg_r.heap_base  <= HEAP_BASE_RESET;
      cfg_r.heap_limit <= HEAP_LIMIT_RESET;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (cfg_index == REG_CLASS_SIZE_0 + REG_IDX_W'(i)) begin
          cfg_r.class_size[i] <= cfg_data[SIZE_W-1:0];
        end
      end
      if (cfg_index == REG_HEAP_BASE) begin
        cfg_r.heap_base <= cfg_data[ADDR_W-1:0];
      end
      if (cfg_index == REG_HEAP_LIMIT) begin
        cfg_r.heap_limit <= cfg_data[ADDR_W-1:0];
      end
    end
  end

endmodule

// ===== src/ssca_class_match.sv =====
// Argument checks and size-class selection for one request.
// Depends on ssca_pkg.
module ssca_class_match (
  input  ssca_pkg::cfg_t     cfg,
  input  ssca_pkg::in_item_t req,
  output ssca_pkg::match_t   match
);
  import ssca_pkg::*;

  logic [NUM_CLASSES-1:0] hit;
  logic                   bad_arg;

  assign bad_arg = (req.req_size == '0) || (cfg.class_size[0] == '0) ||
                   ((req.func == FUNC_FREE) && (req.block_addr == '0));

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (req.func == FUNC_FREE) begin
        hit[i] = (req.req_size == cfg.class_size[i]);
      end else begin
        hit[i] = (req.req_size <= cfg.class_size[i]);
      end
    end
  end

  // Lowest index wins: scan downward so the last assignment is the first hit.
  always_comb begin
    match.cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match.cls = CLS_W'(i);
      end
    end
    priority if (bad_arg) begin
      match.status = ST_BAD_ARG;
    end else if (hit == '0) begin
      match.status = ST_NO_CLASS;
    end else begin
      match.status = ST_OK;
    end
  end

endmodule

// ===== src/ssca_stack_store.sv =====
// Free-stack memory for all classes plus the per-class fill counts.
// Depends on ssca_pkg.
module ssca_stack_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssca_pkg::stk_req_t           req,
  output logic [ssca_pkg::CNT_W-1:0]   cnt_sel,
  output logic [ssca_pkg::ADDR_W-1:0]  rdata
);
  import ssca_pkg::*;

  logic [ADDR_W-1:0] mem [MEM_DEPTH];
  logic [NUM_CLASSES-1:0][CNT_W-1:0] count_r;
  logic [ADDR_W-1:0] rdata_r;
  logic [CNT_W-1:0]  cnt_dec;
  logic [MEM_AW-1:0] base_addr;
  logic [MEM_AW-1:0] waddr;
  logic [MEM_AW-1:0] raddr;

  assign cnt_sel   = count_r[req.cls];
  assign cnt_dec   = cnt_sel - CNT_W'(1);
  assign base_addr = MEM_AW'(req.cls) * MEM_AW'(STACK_DEPTH);
  assign waddr     = base_addr + MEM_AW'(cnt_sel[PTR_W-1:0]);
  assign raddr     = base_addr + MEM_AW'(cnt_dec[PTR_W-1:0]);
  assign rdata     = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req.push) begin
      count_r[req.cls] <= cnt_sel + CNT_W'(1);
    end else if (req.pop) begin
      count_r[req.cls] <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[waddr] <= req.wdata;
    end
    if (req.pop) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== src/slab_size_class_allocator.sv =====
// Top level of the slab size-class allocator: request control and bump region.
// Depends on ssca_pkg, ssca_cfg_regs, ssca_class_match and ssca_stack_store.
//
// Each item is an allocate or a free. It is accepted when start is high and
// busy is low, and its result appears on out_item with out_strobe high for
// exactly one cycle, the cycle right after acceptance; busy is high during
// that cycle, so no new item is taken until the result has been shown. The
// receiver cannot stall: sample out_item whenever out_strobe is high. At the
// accept edge the class is chosen, the class's fill count is read and
// updated, and the free-stack memory is read (pop) or written (push); the
// read data is registered, and the bump-region check is made in the response
// cycle. Allocate pops the newest freed address of the lowest-indexed fitting
// class, or carves heap_base plus the bump offset when that stack is empty.
// Free pushes onto the class whose size matches exactly. Errors return
// address zero and leave all state untouched. No clearing pass is needed
// after reset. Write configuration only while the block is idle; cfg_ready
// is low while busy.
module slab_size_class_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ssca_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output ssca_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssca_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ssca_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssca_pkg::*;

  state_t state_r, state_nxt;

  cfg_t     cfg;
  match_t   match;
  stk_req_t stk_req;
  logic [CNT_W-1:0]  cnt_sel;
  logic [ADDR_W-1:0] stk_rdata;

  logic accept;

  // Per-item decision, captured at the accept edge
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [CLS_W-1:0]  cls_r;
  logic              use_stack_r, use_stack_nxt;
  logic              use_bump_r, use_bump_nxt;

  logic [ADDR_W-1:0] bump_offset_r;
  logic [ADDR_W:0]   bump_sum;
  logic              heap_ok;

  ssca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssca_class_match u_match (
    .cfg   (cfg),
    .req   (in_item),
    .match (match)
  );

  ssca_stack_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .cnt_sel (cnt_sel),
    .rdata   (stk_rdata)
  );

  assign accept = start && (state_r == S_IDLE);

  // Route the item: pop, push, carve from the bump region, or report an error.
  always_comb begin
    stk_req.cls   = match.cls;
    stk_req.wdata = in_item.block_addr;
    stk_req.push  = 1'b0;
    stk_req.pop   = 1'b0;
    stat_nxt      = match.status;
    use_stack_nxt = 1'b0;
    use_bump_nxt  = 1'b0;
    if (match.status == ST_OK) begin
      if (in_item.func == FUNC_ALLOC) begin
        if (cnt_sel != '0) begin
          stk_req.pop   = accept;
          use_stack_nxt = 1'b1;
        end else begin
          use_bump_nxt = 1'b1;
        end
      end else if (cnt_sel == CNT_W'(STACK_DEPTH)) begin
        stat_nxt = ST_STACK_FULL;
      end else begin
        stk_req.push = accept;
      end
    end
  end

  // Bump region check; the sum is one bit wider so it cannot overflow.
  assign bump_sum = {1'b0, bump_offset_r} + (ADDR_W + 1)'(cfg.class_size[cls_r]);
  assign heap_ok  = (bump_sum <= {1'b0, cfg.heap_limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bump_offset_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_RESP) && use_bump_r && heap_ok) begin
        bump_offset_r <= bump_sum[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r      <= stat_nxt;
      cls_r       <= match.cls;
      use_stack_r <= use_stack_nxt;
      use_bump_r  <= use_bump_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = start ? S_RESP : S_IDLE;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy                 = 1'b0;
    out_strobe           = 1'b0;
    out_item.result_addr = '0;
    out_item.status      = stat_r;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_RESP: begin
        busy       = 1'b1;
        out_strobe = 1'b1;
        if (use_stack_r) begin
          out_item.result_addr = stk_rdata;
          out_item.status      = ST_OK;
        end else if (use_bump_r) begin
          if (heap_ok) begin
            out_item.result_addr = cfg.heap_base + bump_offset_r;
            out_item.status      = ST_OK;
          end else begin
            out_item.status = ST_HEAP_FULL;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Hold configuration off while an item is in flight.
  assign cfg_ready = !busy;

endmodule

// ===== src/ssca_checker.sv =====
// Port-level checks for the slab size-class allocator, bound to the top level.
// Depends on ssca_pkg and slab_size_class_allocator.
module ssca_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input ssca_pkg::out_item_t out_item,
  input logic                cfg_ready
);
  import ssca_pkg::*;

  // Every accepted item is answered in the very next cycle.
  a_resp_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("accepted item not answered in next cycle");

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // No item is taken and no configuration accepted while a result is shown.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (busy && !cfg_ready))
    else $error("block not busy while delivering a result");

  // A failed request never returns an address.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_OK)) |-> (out_item.result_addr == '0))
    else $error("nonzero address with error status");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.status == ST_OK || out_item.status == ST_BAD_ARG ||
                    out_item.status == ST_NO_CLASS || out_item.status == ST_HEAP_FULL ||
                    out_item.status == ST_STACK_FULL))
    else $error("undefined status code");

endmodule

bind slab_size_class_allocator ssca_checker u_ssca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item),
  .cfg_ready  (cfg_ready)
);
